@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int POOL_UNITS_DEF = 1024;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] request_size;
        logic [15:0] block_offset;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  result_offset;
        logic [10:0] result_size;
    } rsp_t;

endpackage

`default_nettype wire

@@ sv/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator; the free-size tree lives in one synchronous RAM.
//
//   port group        | direction | handshake
//   cmd               | in        | start && !busy
//   rsp               | out       | done, one cycle, no back-pressure
//
// Allocate: an accept, one root read, one read per level down and one
// read-modify-write per level up. Free and query: one read per level up
// to the block; free then does one read-modify-write per level to the
// root. Out of range offsets, unused opcodes and oversized requests are
// answered in the cycle after they are accepted.
// The single RAM port pair (one read, one write a cycle) sets the pace.
// After reset a clearing pass writes all 2*POOL_UNITS-1 tree nodes;
// busy stays high throughout. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module buddy_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int POOL_UNITS = POOL_UNITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output rsp_t      rsp
);

    localparam int LG    = $clog2(POOL_UNITS);
    localparam int VW    = LG + 1;
    localparam int IW    = LG + 1;
    localparam int NODES = 2 * POOL_UNITS - 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_AROOT = 3'd2;
    localparam logic [2:0] S_ADESC = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_UP    = 3'd5;

    logic [VW-1:0] tree_mem [NODES];
    logic [VW-1:0] rdata_reg;

    logic [2:0]    state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [VW-1:0] nsz_reg, nsz_next;
    logic [VW-1:0] want_reg, want_next;
    logic [VW-1:0] cv_reg, cv_next;
    logic [LG-1:0] base_reg, base_next;
    logic [IW-1:0] clr_idx_reg, clr_idx_next;
    logic [VW-1:0] clr_size_reg, clr_size_next;
    logic          done_reg, done_next;
    rsp_t          rsp_reg, rsp_next;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          we;
    logic [IW-1:0] wr_addr;
    logic [VW-1:0] wr_data;

    logic [VW-1:0] want_c;
    logic          too_big_c;
    logic          off_range_c;
    logic [IW-1:0] leaf_c;

    function automatic logic [IW-1:0] left_of(input logic [IW-1:0] x);
        return {x[IW-2:0], 1'b1};
    endfunction

    function automatic logic [IW-1:0] parent_of(input logic [IW-1:0] x);
        logic [IW-1:0] t;
        t = x - IW'(1);
        return t >> 1;
    endfunction

    function automatic logic [IW-1:0] sibling_of(input logic [IW-1:0] x);
        return x[0] ? (x + IW'(1)) : (x - IW'(1));
    endfunction

    // request decode
    always_comb
    begin
        want_c = VW'(POOL_UNITS);
        for (int k = LG - 1; k >= 0; k--)
        begin
            if ({1'b0, cmd.request_size} <= (17'd1 << k))
            begin
                want_c = VW'(1) << k;
            end
        end
        too_big_c   = {1'b0, cmd.request_size} > 17'(POOL_UNITS);
        off_range_c = {1'b0, cmd.block_offset} >= 17'(POOL_UNITS);
        leaf_c      = {1'b0, cmd.block_offset[LG-1:0]} + IW'(POOL_UNITS - 1);
    end

    // tree RAM
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= tree_mem[rd_addr];
        end
        if (we)
        begin
            tree_mem[wr_addr] <= wr_data;
        end
    end

    logic [IW-1:0] nidx_c;
    logic [IW-1:0] par_c;
    logic [IW-1:0] clr_inc_c;
    logic [IW-1:0] clr_inc1_c;
    logic [VW:0]   sum_c;
    logic [VW-1:0] nsz2_c;
    logic [VW-1:0] newv_c;
    logic [31:0]   base_w;
    logic [31:0]   want_w;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        nsz_next      = nsz_reg;
        want_next     = want_reg;
        cv_next       = cv_reg;
        base_next     = base_reg;
        clr_idx_next  = clr_idx_reg;
        clr_size_next = clr_size_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        we            = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;

        nidx_c     = (rdata_reg >= want_reg) ? left_of(idx_reg) : (left_of(idx_reg) + IW'(1));
        par_c      = parent_of(idx_reg);
        clr_inc_c  = clr_idx_reg + IW'(1);
        clr_inc1_c = clr_inc_c + IW'(1);
        sum_c      = {1'b0, cv_reg} + {1'b0, rdata_reg};
        nsz2_c     = nsz_reg << 1;
        newv_c     = (sum_c == {1'b0, nsz2_c}) ? nsz2_c :
                     ((cv_reg > rdata_reg) ? cv_reg : rdata_reg);
        base_w     = 32'(base_reg);
        want_w     = 32'(want_reg);

        case (state_reg)
            S_CLEAR:
            begin
                we      = 1'b1;
                wr_addr = clr_idx_reg;
                wr_data = clr_size_reg;
                clr_idx_next = clr_inc_c;
                if ((clr_inc1_c & clr_inc_c) == '0)
                begin
                    clr_size_next = clr_size_reg >> 1;
                end
                if (clr_idx_reg == IW'(NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next = cmd.opcode;
                    case (cmd.opcode)
                        OP_ALLOC:
                        begin
                            if (too_big_c)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_NO_SPACE, 10'd0, 11'd0};
                            end
                            else
                            begin
                                want_next  = want_c;
                                idx_next   = '0;
                                nsz_next   = VW'(POOL_UNITS);
                                base_next  = '0;
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                state_next = S_AROOT;
                            end
                        end
                        OP_FREE, OP_QUERY:
                        begin
                            if (off_range_c)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_RANGE, 10'd0, 11'd0};
                            end
                            else
                            begin
                                idx_next   = leaf_c;
                                nsz_next   = VW'(1);
                                base_next  = '0;
                                rd_en      = 1'b1;
                                rd_addr    = leaf_c;
                                state_next = S_FIND;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{ST_OK, 10'd0, 11'd0};
                        end
                    endcase
                end
            end

            S_AROOT:
            begin
                if (rdata_reg < want_reg)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{ST_NO_SPACE, 10'd0, 11'd0};
                    state_next = S_IDLE;
                end
                else if (nsz_reg == want_reg)
                begin
                    we         = 1'b1;
                    wr_addr    = '0;
                    wr_data    = '0;
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OK, 10'd0, want_w[10:0]};
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = left_of(idx_reg);
                    state_next = S_ADESC;
                end
            end

            S_ADESC:
            begin
                idx_next = nidx_c;
                nsz_next = nsz_reg >> 1;
                if (rdata_reg < want_reg)
                begin
                    base_next = base_reg + LG'(nsz_reg >> 1);
                end
                if ((nsz_reg >> 1) == want_reg)
                begin
                    we         = 1'b1;
                    wr_addr    = nidx_c;
                    wr_data    = '0;
                    cv_next    = '0;
                    rd_en      = 1'b1;
                    rd_addr    = sibling_of(nidx_c);
                    state_next = S_UP;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = left_of(nidx_c);
                end
            end

            S_FIND:
            begin
                if (rdata_reg != '0)
                begin
                    if (idx_reg == '0)
                    begin
                        done_next  = 1'b1;
                        rsp_next   = '{ST_NOT_ALLOC, 10'd0, 11'd0};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = par_c;
                        nsz_next = nsz2_c;
                        rd_en    = 1'b1;
                        rd_addr  = par_c;
                    end
                end
                else
                begin
                    want_next = nsz_reg;
                    if (op_reg == OP_QUERY || idx_reg == '0)
                    begin
                        if (op_reg == OP_FREE)
                        begin
                            we      = 1'b1;
                            wr_addr = idx_reg;
                            wr_data = nsz_reg;
                        end
                        done_next  = 1'b1;
                        rsp_next   = '{ST_OK, 10'd0, 11'(32'(nsz_reg))};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wr_addr    = idx_reg;
                        wr_data    = nsz_reg;
                        cv_next    = nsz_reg;
                        rd_en      = 1'b1;
                        rd_addr    = sibling_of(idx_reg);
                        state_next = S_UP;
                    end
                end
            end

            S_UP:
            begin
                we       = 1'b1;
                wr_addr  = par_c;
                wr_data  = newv_c;
                idx_next = par_c;
                cv_next  = newv_c;
                nsz_next = nsz2_c;
                if (par_c == '0)
                begin
                    done_next  = 1'b1;
                    rsp_next   = '{ST_OK, base_w[9:0], want_w[10:0]};
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = sibling_of(par_c);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            clr_size_reg <= VW'(POOL_UNITS);
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            clr_size_reg <= clr_size_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        idx_reg  <= idx_next;
        nsz_reg  <= nsz_next;
        want_reg <= want_next;
        cv_reg   <= cv_next;
        base_reg <= base_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `BBA_ASSERT_IMPL(a_no_same_entry, rd_en && we, rd_addr != wr_addr, "read and write hit one entry")
    `BBA_ASSERT_IMPL(a_err_zero, done_reg && (rsp_reg.status != ST_OK), (rsp_reg.result_offset == 10'd0) && (rsp_reg.result_size == 11'd0), "error result carries data")
    `BBA_ASSERT_NEXT(a_accept_resp, start && !busy, busy || done_reg, "accepted transfer dropped")
    `BBA_ASSERT_IMPL(a_clear_quiet, state_reg == S_CLEAR, !done_reg, "result during clearing pass")

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the buddy block allocator. A behavioural copy of
// the free-size tree predicts the response of every accepted command; the
// monitor compares each strobed response with the oldest prediction.
// Directed tests cover rounding, error codes and the full pool, then
// random traffic mixes allocate, free and query over the live blocks.
// ----------------------------------------------------------------------------
module testbench;

    import bba_pkg::*;

    localparam int unsigned POOL       = POOL_UNITS_DEF;
    localparam int unsigned NODE_COUNT = 2 * POOL - 1;
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 40;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic done;
    rsp_t rsp;

    logic [10:0] free_size_tree [0:NODE_COUNT-1];
    rsp_t        expected_responses [$];
    rsp_t        head_response;
    int unsigned live_base [$];
    int unsigned live_size [$];
    int unsigned mismatch_count;
    bit          gaps_enabled;

    buddy_block_allocator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic void reset_tree();
        int unsigned sz;
        sz = 2 * POOL;
        for (int unsigned i = 0; i < NODE_COUNT; i++)
        begin
            if (((i + 1) & i) == 0)
                sz = sz >> 1;
            free_size_tree[i] = sz[10:0];
        end
    endfunction

    function automatic rsp_t predict_response(input cmd_t c);
        rsp_t        r;
        int unsigned want;
        int unsigned idx;
        int unsigned nsz;
        int unsigned sz;
        int unsigned l;
        int unsigned rt;
        bit          found;
        r = '0;
        if (c.opcode == OP_ALLOC)
        begin
            want = 1;
            while (want < c.request_size)
                want = want << 1;
            if (free_size_tree[0] < want)
                r.status = ST_NO_SPACE;
            else
            begin
                idx = 0;
                for (nsz = POOL; nsz != want; nsz = nsz >> 1)
                    idx = (free_size_tree[2 * idx + 1] >= want) ? 2 * idx + 1 : 2 * idx + 2;
                free_size_tree[idx] = '0;
                r.status        = ST_OK;
                r.result_offset = 10'(((idx + 1) * nsz - POOL) & 32'h3FF);
                r.result_size   = want[10:0];
                while (idx != 0)
                begin
                    idx = (idx - 1) / 2;
                    l   = free_size_tree[2 * idx + 1];
                    rt  = free_size_tree[2 * idx + 2];
                    free_size_tree[idx] = (l > rt) ? l[10:0] : rt[10:0];
                end
            end
        end
        else if (c.opcode == OP_UNUSED)
            r.status = ST_OK;
        else if (c.block_offset >= POOL)
            r.status = ST_RANGE;
        else
        begin
            idx   = c.block_offset + POOL - 1;
            sz    = 1;
            found = 1'b1;
            while (found && free_size_tree[idx] != 0)
            begin
                if (idx == 0)
                    found = 1'b0;
                else
                begin
                    idx = (idx - 1) / 2;
                    sz  = sz << 1;
                end
            end
            if (!found)
                r.status = ST_NOT_ALLOC;
            else
            begin
                r.status      = ST_OK;
                r.result_size = sz[10:0];
                if (c.opcode == OP_FREE)
                begin
                    free_size_tree[idx] = sz[10:0];
                    nsz = sz;
                    while (idx != 0)
                    begin
                        idx = (idx - 1) / 2;
                        nsz = nsz << 1;
                        l   = free_size_tree[2 * idx + 1];
                        rt  = free_size_tree[2 * idx + 2];
                        if (l + rt == nsz)
                            free_size_tree[idx] = nsz[10:0];
                        else
                            free_size_tree[idx] = (l > rt) ? l[10:0] : rt[10:0];
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic send_command(input logic [1:0] op, input logic [15:0] req,
                                input logic [15:0] off);
        cmd_t        c;
        rsp_t        r;
        int unsigned base;
        c.opcode       = op;
        c.request_size = req;
        c.block_offset = off;
        while (gaps_enabled && $urandom_range(99) < 9)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        cmd   <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        r = predict_response(c);
        expected_responses.push_back(r);
        if (r.status == ST_OK && op == OP_ALLOC)
        begin
            live_base.push_back(32'(r.result_offset));
            live_size.push_back(32'(r.result_size));
        end
        else if (r.status == ST_OK && op == OP_FREE)
        begin
            base = 32'(off) & ~(32'(r.result_size) - 1);
            for (int i = live_base.size() - 1; i >= 0; i--)
                if (live_base[i] == base)
                begin
                    live_base.delete(i);
                    live_size.delete(i);
                end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: response with none expected, actual st=%0d off=%0d size=%0d",
                         $time, rsp.status, rsp.result_offset, rsp.result_size);
                mismatch_count++;
            end
            else
            begin
                head_response = expected_responses.pop_front();
                if (rsp !== head_response)
                begin
                    $display("%0t: mismatch, expected st=%0d off=%0d size=%0d, actual st=%0d off=%0d size=%0d",
                             $time, head_response.status, head_response.result_offset,
                             head_response.result_size, rsp.status, rsp.result_offset,
                             rsp.result_size);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_allocate_rounding();
        send_command(OP_ALLOC, 16'd0, 16'd0);
        send_command(OP_ALLOC, 16'd1, 16'hFFFF);
        send_command(OP_ALLOC, 16'd3, 16'd0);
        send_command(OP_QUERY, 16'hFFFF, 16'd5);
        send_command(OP_QUERY, 16'd0, 16'd1);
        send_command(OP_FREE, 16'd0, 16'd6);
        send_command(OP_FREE, 16'd0, 16'd0);
        send_command(OP_FREE, 16'd0, 16'd1);
    endtask

    task automatic test_error_codes();
        send_command(OP_QUERY, 16'd0, 16'd100);
        send_command(OP_FREE, 16'd0, 16'd0);
        send_command(OP_FREE, 16'd0, 16'(POOL));
        send_command(OP_FREE, 16'd0, 16'hFFFF);
        send_command(OP_QUERY, 16'd0, 16'hFFFF);
        send_command(OP_UNUSED, 16'hFFFF, 16'hFFFF);
        send_command(OP_ALLOC, 16'(POOL + 1), 16'd0);
        send_command(OP_ALLOC, 16'hFFFF, 16'd0);
    endtask

    task automatic test_whole_pool();
        send_command(OP_ALLOC, 16'(POOL), 16'd0);
        send_command(OP_ALLOC, 16'd1, 16'd0);
        send_command(OP_QUERY, 16'd0, 16'(POOL - 1));
        send_command(OP_FREE, 16'd0, 16'(POOL / 2));
        send_command(OP_ALLOC, 16'(POOL / 2), 16'd0);
        send_command(OP_ALLOC, 16'(POOL / 2 - 1), 16'd0);
        send_command(OP_ALLOC, 16'd1, 16'd0);
        send_command(OP_FREE, 16'd0, 16'(POOL - 1));
        send_command(OP_FREE, 16'd0, 16'd0);
    endtask

    task automatic test_random_traffic(input int unsigned item_count);
        logic [1:0]  op;
        logic [15:0] req;
        logic [15:0] off;
        int unsigned roll;
        int unsigned pick;
        int unsigned which;
        for (int unsigned n = 0; n < item_count; n++)
        begin
            gaps_enabled = !(n >= 250 && n < 400);
            roll = $urandom_range(99);
            if (live_base.size() == 0)
                op = (roll < 85) ? OP_ALLOC : 2'($urandom_range(3));
            else if (free_size_tree[0] < 16)
                op = (roll < 70) ? OP_FREE : (roll < 85) ? OP_QUERY : OP_ALLOC;
            else if (roll < 45)
                op = OP_ALLOC;
            else if (roll < 80)
                op = OP_FREE;
            else if (roll < 95)
                op = OP_QUERY;
            else
                op = 2'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 60)
                req = 16'($urandom_range(8));
            else if (pick < 85)
                req = 16'($urandom_range(64, 9));
            else if (pick < 95)
                req = 16'($urandom_range(POOL, 65));
            else
                req = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 70 && live_base.size() != 0)
            begin
                which = $urandom_range(live_base.size() - 1);
                off   = 16'(live_base[which] + $urandom_range(live_size[which] - 1));
            end
            else if (pick < 88)
                off = 16'($urandom_range(POOL - 1));
            else
                off = 16'($urandom);
            send_command(op, req, off);
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        cmd            <= '0;
        mismatch_count  = 0;
        gaps_enabled    = 1'b1;
        reset_tree();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_allocate_rounding();
        test_error_codes();
        test_whole_pool();
        test_random_traffic(750);

        start <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
